>>> rtl/core/lfsl_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LIFO free slot list - shared definitions
// Sizes, opcodes and the link memory request bundle.
// ----------------------------------------------------------------------------
package lfsl_pkg;

  localparam int SLOTS   = 1024;
  localparam int SLOT_W  = 10;
  localparam int ADDR_W  = $clog2(SLOTS);
  localparam int LINK_W  = SLOT_W + 1;          // {valid, slot}
  localparam int CNT_W   = $clog2(SLOTS + 1);
  localparam int COUNT_W = 11;
  localparam int OP_W    = 2;

  localparam logic [OP_W-1:0] OP_ALLOC   = 2'd0;
  localparam logic [OP_W-1:0] OP_RELEASE = 2'd1;
  localparam logic [OP_W-1:0] OP_COUNT   = 2'd2;

  typedef struct packed {
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    logic [LINK_W-1:0] wr_data;
    logic              rd_en;
    logic [ADDR_W-1:0] rd_addr;
  } mem_req_t;

endpackage

>>> rtl/core/lfsl_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LIFO free slot list - channel interfaces
// Request and result channels, valid/ready handshake.
// ----------------------------------------------------------------------------
interface lfsl_in_if;
  logic                            valid;
  logic                            ready;
  logic [lfsl_pkg::OP_W-1:0]       opcode;
  logic [lfsl_pkg::SLOT_W-1:0]     slot;

  modport source (output valid, output opcode, output slot, input ready);
  modport sink   (input valid, input opcode, input slot, output ready);
endinterface

interface lfsl_out_if;
  logic                            valid;
  logic                            ready;
  logic [lfsl_pkg::SLOT_W-1:0]     slot_out;
  logic                            status;
  logic [lfsl_pkg::COUNT_W-1:0]    free_count;

  modport source (output valid, output slot_out, output status, output free_count,
                  input ready);
  modport sink   (input valid, input slot_out, input status, input free_count,
                  output ready);
endinterface

>>> rtl/core/lifo_free_slot_list.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LIFO free slot list
// Stack of free record slots: head register plus a next-link memory.
// ----------------------------------------------------------------------------
//  channel  dir  fields                          notes
//  in_chan  in   opcode, slot                    alloc / release / count
//  out_chan out  slot_out, status, free_count    one result per request
//
// Release and unused opcode: result straight from the accepting state. Allocate:
// one link memory read of the head's link, result from S_POP; at once on an empty list.
// Count: walks the chain, one link read per hop, at most SLOTS hops.
// A result that meets a still occupied output register waits in S_HOLD.
// Sync reset clears head valid and control; link memory needs no clearing.
// Output stalls are absorbed by a pending result register.
module lifo_free_slot_list (
  input  logic              clk,
  input  logic              rst_n,
  lfsl_in_if.sink           in_chan,
  lfsl_out_if.source        out_chan
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_POP  = 2'd1;
  localparam logic [1:0] S_WALK = 2'd2;
  localparam logic [1:0] S_HOLD = 2'd3;

  logic [1:0]                    state_r, state_nxt;
  logic                          head_valid_r, head_valid_nxt;
  logic [lfsl_pkg::SLOT_W-1:0]   head_slot_r, head_slot_nxt;
  logic [lfsl_pkg::CNT_W-1:0]    cnt_r, cnt_nxt;

  logic [lfsl_pkg::SLOT_W-1:0]   pend_slot_r, pend_slot_nxt;
  logic                          pend_status_r, pend_status_nxt;
  logic [lfsl_pkg::COUNT_W-1:0]  pend_count_r, pend_count_nxt;

  logic                          out_valid_r, out_valid_nxt;
  logic [lfsl_pkg::SLOT_W-1:0]   out_slot_r, out_slot_nxt;
  logic                          out_status_r, out_status_nxt;
  logic [lfsl_pkg::COUNT_W-1:0]  out_count_r, out_count_nxt;

  logic                          fin_valid;
  logic [lfsl_pkg::SLOT_W-1:0]   fin_slot;
  logic                          fin_status;
  logic [lfsl_pkg::COUNT_W-1:0]  fin_count;

  lfsl_pkg::mem_req_t            mem_req;
  logic [lfsl_pkg::LINK_W-1:0]   rd_data_r;

  logic                          in_fire;
  logic                          out_free;
  logic                          slot_ok;
  logic                          lnk_valid;
  logic [lfsl_pkg::SLOT_W-1:0]   lnk_slot;

  lfsl_link_mem u_link_mem (
    .clk       (clk),
    .req       (mem_req),
    .rd_data_r (rd_data_r)
  );

  assign in_chan.ready = (state_r == S_IDLE);
  assign in_fire       = in_chan.valid && in_chan.ready;
  assign out_free      = !out_valid_r || out_chan.ready;
  assign slot_ok       = (32'(in_chan.slot) < lfsl_pkg::SLOTS);
  assign lnk_valid     = rd_data_r[lfsl_pkg::LINK_W-1];
  assign lnk_slot      = rd_data_r[lfsl_pkg::SLOT_W-1:0];

  assign out_chan.valid      = out_valid_r;
  assign out_chan.slot_out   = out_slot_r;
  assign out_chan.status     = out_status_r;
  assign out_chan.free_count = out_count_r;

  always_comb begin
    state_nxt      = state_r;
    head_valid_nxt = head_valid_r;
    head_slot_nxt  = head_slot_r;
    cnt_nxt        = cnt_r;
    mem_req        = '0;
    fin_valid      = 1'b0;
    fin_slot       = '0;
    fin_status     = 1'b0;
    fin_count      = '0;

    case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          case (in_chan.opcode)
            lfsl_pkg::OP_ALLOC: begin
              if (head_valid_r) begin
                mem_req.rd_en   = 1'b1;
                mem_req.rd_addr = lfsl_pkg::ADDR_W'(head_slot_r);
                state_nxt       = S_POP;
              end else begin
                fin_valid  = 1'b1;
                fin_status = 1'b1;
              end
            end
            lfsl_pkg::OP_RELEASE: begin
              fin_valid = 1'b1;
              if (slot_ok) begin
                mem_req.wr_en   = 1'b1;
                mem_req.wr_addr = lfsl_pkg::ADDR_W'(in_chan.slot);
                mem_req.wr_data = {head_valid_r, head_slot_r};
                head_valid_nxt  = 1'b1;
                head_slot_nxt   = in_chan.slot;
              end
            end
            lfsl_pkg::OP_COUNT: begin
              if (head_valid_r) begin
                mem_req.rd_en   = 1'b1;
                mem_req.rd_addr = lfsl_pkg::ADDR_W'(head_slot_r);
                cnt_nxt         = lfsl_pkg::CNT_W'(1);
                state_nxt       = S_WALK;
              end else begin
                fin_valid = 1'b1;
              end
            end
            default: begin
              fin_valid = 1'b1;
            end
          endcase
        end
      end
      S_POP: begin
        fin_valid      = 1'b1;
        fin_slot       = head_slot_r;
        head_valid_nxt = lnk_valid;
        head_slot_nxt  = lnk_slot;
      end
      S_WALK: begin
        // stop at end of chain or after SLOTS hops (guards against loops)
        if (!lnk_valid || (cnt_r == lfsl_pkg::CNT_W'(lfsl_pkg::SLOTS))) begin
          fin_valid = 1'b1;
          fin_count = lfsl_pkg::COUNT_W'(cnt_r);
        end else begin
          mem_req.rd_en   = 1'b1;
          mem_req.rd_addr = lfsl_pkg::ADDR_W'(lnk_slot);
          cnt_nxt         = cnt_r + lfsl_pkg::CNT_W'(1);
        end
      end
      S_HOLD: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    if (fin_valid) begin
      state_nxt = out_free ? S_IDLE : S_HOLD;
    end
  end

  // output register and pending result
  always_comb begin
    out_valid_nxt   = out_valid_r && !out_chan.ready;
    out_slot_nxt    = out_slot_r;
    out_status_nxt  = out_status_r;
    out_count_nxt   = out_count_r;
    pend_slot_nxt   = pend_slot_r;
    pend_status_nxt = pend_status_r;
    pend_count_nxt  = pend_count_r;

    if (state_r == S_HOLD) begin
      if (out_free) begin
        out_valid_nxt  = 1'b1;
        out_slot_nxt   = pend_slot_r;
        out_status_nxt = pend_status_r;
        out_count_nxt  = pend_count_r;
      end
    end else if (fin_valid) begin
      if (out_free) begin
        out_valid_nxt  = 1'b1;
        out_slot_nxt   = fin_slot;
        out_status_nxt = fin_status;
        out_count_nxt  = fin_count;
      end else begin
        pend_slot_nxt   = fin_slot;
        pend_status_nxt = fin_status;
        pend_count_nxt  = fin_count;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      head_valid_r <= 1'b0;
      head_slot_r  <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      head_valid_r <= head_valid_nxt;
      head_slot_r  <= head_slot_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cnt_r         <= cnt_nxt;
    pend_slot_r   <= pend_slot_nxt;
    pend_status_r <= pend_status_nxt;
    pend_count_r  <= pend_count_nxt;
    out_slot_r    <= out_slot_nxt;
    out_status_r  <= out_status_nxt;
    out_count_r   <= out_count_nxt;
  end

`ifndef NO_ASSERTIONS
  a_no_rw_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(mem_req.wr_en && mem_req.rd_en))
    else $error("link memory read and write in the same cycle");

  a_hold_needs_busy_out: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_HOLD) |-> out_valid_r)
    else $error("pending result while output register is empty");

  a_walk_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_WALK) |->
      (cnt_r != '0) && (cnt_r <= lfsl_pkg::CNT_W'(lfsl_pkg::SLOTS)))
    else $error("count walk out of bounds");

  a_release_push: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && (in_chan.opcode == lfsl_pkg::OP_RELEASE) && slot_ok) |=>
      (head_valid_r && (head_slot_r == $past(in_chan.slot))))
    else $error("released slot did not become the head");
`endif

endmodule

>>> rtl/core/lfsl_link_mem.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LIFO free slot list - link memory
// One next-link word per slot, one write and one read port, registered read.
// ----------------------------------------------------------------------------
module lfsl_link_mem (
  input  logic                        clk,
  input  lfsl_pkg::mem_req_t          req,
  output logic [lfsl_pkg::LINK_W-1:0] rd_data_r
);

  logic [lfsl_pkg::LINK_W-1:0] mem [lfsl_pkg::SLOTS];

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.wr_addr] <= req.wr_data;
    end
    if (req.rd_en) begin
      rd_data_r <= mem[req.rd_addr];
    end
  end

endmodule

>>> sim/lfsl_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LIFO free slot list - result checker
// Watches the request and result channels, keeps its own copy of the free
// list (head register plus link table), predicts one result per accepted
// request and compares each result transfer field by field, in order.
// ----------------------------------------------------------------------------
module lfsl_checker (
  input  logic       clk,
  input  logic       rst_n,
  lfsl_in_if         in_mon,
  lfsl_out_if        out_mon,
  output int         fail_cnt,
  output int         pending,
  output int         checked
);
  import lfsl_pkg::*;

  localparam logic ST_DONE  = 1'b0;
  localparam logic ST_EMPTY = 1'b1;
  localparam int   COUNT_SAT = (1 << COUNT_W) - 1;

  typedef struct packed {
    logic [SLOT_W-1:0]  slot_out;
    logic               status;
    logic [COUNT_W-1:0] free_count;
  } slot_result_t;

  // shadow free list
  bit                top_valid;
  bit [SLOT_W-1:0]   top_slot;
  bit [LINK_W-1:0]   link_tbl [SLOTS];

  slot_result_t      want_q [$];
  int                err_n;
  int                seen_n;

  function automatic slot_result_t apply_request(logic [OP_W-1:0] op,
                                                 logic [SLOT_W-1:0] slot);
    slot_result_t      r;
    bit [LINK_W-1:0]   lnk;
    bit                walk_valid;
    bit [SLOT_W-1:0]   cur;
    int                hops;
    r = '0;
    case (op)
      OP_ALLOC: begin
        if (!top_valid) begin
          r.status = ST_EMPTY;
        end else begin
          lnk        = link_tbl[top_slot];
          r.slot_out = top_slot;
          r.status   = ST_DONE;
          top_valid  = lnk[SLOT_W];
          top_slot   = lnk[SLOT_W-1:0];
        end
      end
      OP_RELEASE: begin
        if (int'(slot) < SLOTS) begin
          link_tbl[slot] = {top_valid, top_slot};
          top_valid      = 1'b1;
          top_slot       = slot;
        end
      end
      OP_COUNT: begin
        hops       = 0;
        walk_valid = top_valid;
        cur        = top_slot;
        // a looping chain is cut off after SLOTS hops
        while (walk_valid && hops < SLOTS) begin
          hops++;
          lnk        = link_tbl[cur];
          walk_valid = lnk[SLOT_W];
          cur        = lnk[SLOT_W-1:0];
        end
        r.free_count = (hops > COUNT_SAT) ? COUNT_SAT[COUNT_W-1:0] : hops[COUNT_W-1:0];
      end
      default: ;
    endcase
    return r;
  endfunction

  always @(posedge clk) begin : monitor
    slot_result_t got;
    slot_result_t want;
    if (!rst_n) begin
      top_valid = 1'b0;
      top_slot  = '0;
      want_q.delete();
      err_n     = 0;
      seen_n    = 0;
    end else begin
      if (out_mon.valid && out_mon.ready) begin
        got = '{out_mon.slot_out, out_mon.status, out_mon.free_count};
        seen_n++;
        if (want_q.size() == 0) begin
          err_n++;
          $display("%0t: result transfer with nothing expected: slot_out %0d status %0d count %0d",
                   $time, got.slot_out, got.status, got.free_count);
        end else begin
          want = want_q.pop_front();
          if (got.slot_out !== want.slot_out) begin
            err_n++;
            $display("%0t: slot_out expected %0d, got %0d", $time, want.slot_out, got.slot_out);
          end
          if (got.status !== want.status) begin
            err_n++;
            $display("%0t: status expected %0d, got %0d", $time, want.status, got.status);
          end
          if (got.free_count !== want.free_count) begin
            err_n++;
            $display("%0t: free_count expected %0d, got %0d", $time, want.free_count,
                     got.free_count);
          end
        end
      end
      // a request cannot produce its result on the edge that accepts it
      if (in_mon.valid && in_mon.ready)
        want_q.push_back(apply_request(in_mon.opcode, in_mon.slot));
    end
    fail_cnt <= err_n;
    checked  <= seen_n;
    pending  <= want_q.size();
  end

endmodule

>>> sim/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LIFO free slot list - testbench top
// Drives allocate / release / count requests with bursty timing, stalls the
// result side, and reports the verdict from the checker's failure count.
// ----------------------------------------------------------------------------
module tb;
  import lfsl_pkg::*;

  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
  localparam int HOLD_AFTER  = 200;    // requests sent before the long stall
  localparam int HOLD_CYCLES = 400;
  localparam int DRAIN_LIMIT = 20000;

  logic clk;
  logic rst_n;

  lfsl_in_if  in_if ();
  lfsl_out_if out_if ();

  int fail_cnt;
  int pending_cnt;
  int checked_cnt;

  lifo_free_slot_list u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_if),
    .out_chan (out_if)
  );

  lfsl_checker u_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_mon   (in_if),
    .out_mon  (out_if),
    .fail_cnt (fail_cnt),
    .pending  (pending_cnt),
    .checked  (checked_cnt)
  );

  // mirror of the free stack, only used to shape the stimulus
  int free_stack [$];
  bit slot_free [SLOTS];
  int peak_free;
  int sent_total;
  int sent_by_op [4];
  int burst_left;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #20_000_000;
    $display("Timeout waiting for the free list to finish");
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  task automatic send_req(input logic [OP_W-1:0] op, input logic [SLOT_W-1:0] slot);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 4) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        in_if.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 40);
    end
    burst_left--;
    in_if.valid  <= 1'b1;
    in_if.opcode <= op;
    in_if.slot   <= slot;
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
    sent_total++;
    sent_by_op[op]++;
    case (op)
      OP_ALLOC: begin
        if (free_stack.size() > 0) slot_free[free_stack.pop_back()] = 1'b0;
      end
      OP_RELEASE: begin
        free_stack.push_back(int'(slot));
        slot_free[slot] = 1'b1;
        if (free_stack.size() > peak_free) peak_free = free_stack.size();
      end
      default: ;
    endcase
  endtask

  // a slot that is currently handed out; caller makes sure one exists
  function automatic logic [SLOT_W-1:0] pick_used();
    int s;
    do s = $urandom_range(0, SLOTS - 1); while (slot_free[s]);
    return s[SLOT_W-1:0];
  endfunction

  task automatic random_mix(input int n_items, input int w_alloc, input int w_rel,
                            input int w_count);
    int r;
    for (int i = 0; i < n_items; i++) begin
      r = $urandom_range(0, 99);
      if (r < w_alloc || (r < w_alloc + w_rel && free_stack.size() >= SLOTS))
        send_req(OP_ALLOC, SLOT_W'($urandom));
      else if (r < w_alloc + w_rel)
        send_req(OP_RELEASE, pick_used());
      else if (r < w_alloc + w_rel + w_count)
        send_req(OP_COUNT, SLOT_W'($urandom));
      else
        send_req(OP_UNUSED, SLOT_W'($urandom));
    end
  endtask

  task automatic wait_drained();
    int waited;
    waited = 0;
    @(posedge clk);
    while (pending_cnt != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
  endtask

  // result side: random stall pattern plus one long hold-off
  initial begin : rx_pattern
    int  seg;
    int  len;
    bit  held;
    out_if.ready <= 1'b0;
    held = 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (!held && sent_total >= HOLD_AFTER) begin
        held = 1'b1;
        out_if.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      seg = $urandom_range(0, 3);
      len = (seg == 2) ? $urandom_range(1, 8) : $urandom_range(1, 40);
      for (int k = 0; k < len; k++) begin
        case (seg)
          0:       out_if.ready <= 1'b1;
          1:       out_if.ready <= 1'($urandom_range(0, 1));
          2:       out_if.ready <= 1'b0;
          default: out_if.ready <= (k % 3 == 0);
        endcase
        @(posedge clk);
      end
    end
  end

  initial begin : stimulus
    logic [SLOT_W-1:0] order [$];
    logic [SLOT_W-1:0] tmp;
    logic [SLOT_W-1:0] s;
    int j;

    rst_n        <= 1'b0;
    in_if.valid  <= 1'b0;
    in_if.opcode <= OP_ALLOC;
    in_if.slot   <= '0;
    burst_left = 0;
    sent_total = 0;
    peak_free  = 0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // directed: empty list, unused opcode, slot extremes, LIFO order
    send_req(OP_ALLOC,   10'h3FF);
    send_req(OP_COUNT,   10'h3FF);
    send_req(OP_UNUSED,  10'h3FF);
    send_req(OP_RELEASE, 10'h000);
    send_req(OP_RELEASE, 10'h3FF);
    send_req(OP_RELEASE, 10'h155);
    send_req(OP_RELEASE, 10'h2AA);
    send_req(OP_COUNT,   10'h000);
    send_req(OP_UNUSED,  10'h000);
    send_req(OP_COUNT,   10'h155);
    repeat (4) send_req(OP_ALLOC, 10'h000);
    send_req(OP_ALLOC,   10'h2AA);
    send_req(OP_RELEASE, 10'h200);
    send_req(OP_ALLOC,   10'h155);
    send_req(OP_ALLOC,   10'h000);
    send_req(OP_COUNT,   10'h3FF);

    // small list around empty; the long result stall lands in here
    random_mix(550, 40, 40, 12);

    // sender pause until every result is back
    in_if.valid <= 1'b0;
    burst_left = 0;
    wait_drained();

    // fill every handed-out slot in random order, counting now and then
    for (int k = 0; k < SLOTS; k++)
      if (!slot_free[k]) order.push_back(k[SLOT_W-1:0]);
    for (int k = order.size() - 1; k > 0; k--) begin
      j = $urandom_range(0, k);
      tmp = order[k];
      order[k] = order[j];
      order[j] = tmp;
    end
    foreach (order[k]) begin
      if ($urandom_range(0, 99) == 0) send_req(OP_COUNT, SLOT_W'($urandom));
      send_req(OP_RELEASE, order[k]);
    end
    send_req(OP_COUNT, SLOT_W'($urandom));
    send_req(OP_ALLOC, SLOT_W'($urandom));
    send_req(OP_RELEASE, free_stack.size() < SLOTS ? pick_used() : 10'h000);
    send_req(OP_COUNT, SLOT_W'($urandom));

    // partial drain of a long list
    random_mix(350, 55, 30, 10);

    // double release closes a loop; the walk must stop at SLOTS hops
    s = SLOT_W'($urandom_range(0, SLOTS - 1));
    send_req(OP_RELEASE, s);
    send_req(OP_RELEASE, s);
    send_req(OP_COUNT, SLOT_W'($urandom));
    send_req(OP_ALLOC, SLOT_W'($urandom));
    send_req(OP_COUNT, SLOT_W'($urandom));
    send_req(OP_UNUSED, SLOT_W'($urandom));
    send_req(OP_ALLOC, SLOT_W'($urandom));

    in_if.valid <= 1'b0;
    wait_drained();
    repeat (20) @(posedge clk);

    $display("Covered %0d requests: %0d allocate, %0d release, %0d count, %0d unused opcode",
             sent_total, sent_by_op[OP_ALLOC], sent_by_op[OP_RELEASE],
             sent_by_op[OP_COUNT], sent_by_op[OP_UNUSED]);
    $display("%0d results checked; free list peaked at %0d slots, ending with a looped chain",
             checked_cnt, peak_free);
    if (pending_cnt != 0)
      $display("%0d expected results never arrived", pending_cnt);
    if (fail_cnt == 0 && pending_cnt == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

>>> lifo_free_slot_list.f
rtl/core/lfsl_pkg.sv
rtl/core/lfsl_if.sv
rtl/core/lfsl_link_mem.sv
rtl/core/lifo_free_slot_list.sv
sim/lfsl_checker.sv
sim/tb.sv
